>>> design/rlim_pkg.sv
// ----------------------------------------------------------------------------
// rlim_pkg
// Shared types, sizes and codes of the run-length index map.
// ----------------------------------------------------------------------------
`default_nettype none

package rlim_pkg;

  localparam int MAX_RUNS   = 1024;
  localparam int INDEX_BITS = 48;
  localparam int RUN_AW     = $clog2(MAX_RUNS);
  localparam int COUNT_W    = $clog2(MAX_RUNS + 1);

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [RUN_AW-1:0]     addr_t;

  localparam index_t IDX_ONES  = {INDEX_BITS{1'b1}};
  localparam count_t COUNT_MAX = COUNT_W'(MAX_RUNS);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_FINAL,
    ST_ADD,
    ST_RESP
  } state_t;

  // One stored run; the destination end is implied by the source length.
  typedef struct packed {
    index_t src_start;
    index_t src_end;
    index_t dst_start;
  } run_entry_t;

  typedef struct packed {
    logic load;
    logic append;
    logic clear;
    logic search_init;
    logic search_step;
    logic final_check;
    logic add_dest;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic search_more;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> design/rlim_ram.sv
// ----------------------------------------------------------------------------
// rlim_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rlim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/rlim_ctrl.sv
// ----------------------------------------------------------------------------
// rlim_ctrl
// Sequencer: accept a word, run append, clear or search, then hand out result.
// ----------------------------------------------------------------------------
`default_nettype none

module rlim_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rlim_pkg::stat_t stat,
  output rlim_pkg::cmd_t       cmd
);

  rlim_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlim_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rlim_pkg::ST_IDLE: begin
        if (in_valid) state_next = rlim_pkg::ST_EXEC;
      end
      rlim_pkg::ST_EXEC: begin
        if (stat.op == rlim_pkg::OP_LOOKUP && !stat.empty) begin
          state_next = rlim_pkg::ST_SEARCH;
        end else begin
          state_next = rlim_pkg::ST_RESP;
        end
      end
      rlim_pkg::ST_SEARCH: begin
        if (!stat.search_more) state_next = rlim_pkg::ST_FINAL;
      end
      rlim_pkg::ST_FINAL: state_next = rlim_pkg::ST_ADD;
      rlim_pkg::ST_ADD:   state_next = rlim_pkg::ST_RESP;
      rlim_pkg::ST_RESP: begin
        if (stat.out_free) state_next = rlim_pkg::ST_IDLE;
      end
      default: state_next = rlim_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      rlim_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rlim_pkg::ST_EXEC: begin
        cmd.append      = (stat.op == rlim_pkg::OP_APPEND);
        cmd.clear       = (stat.op == rlim_pkg::OP_CLEAR);
        cmd.search_init = (stat.op == rlim_pkg::OP_LOOKUP);
      end
      rlim_pkg::ST_SEARCH: cmd.search_step = 1'b1;
      rlim_pkg::ST_FINAL:  cmd.final_check = 1'b1;
      rlim_pkg::ST_ADD:    cmd.add_dest    = 1'b1;
      rlim_pkg::ST_RESP:   cmd.out_load    = stat.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/rlim_datapath.sv
// ----------------------------------------------------------------------------
// rlim_datapath
// Run table, last-run registers, binary search unit and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlim_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rlim_pkg::cmd_t  cmd,
  output rlim_pkg::stat_t      stat,
  input  wire logic [1:0]      op,
  input  wire logic [47:0]     append_value,
  input  wire logic [47:0]     lookup_index,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic                 found,
  output logic [47:0]          dest_index,
  output logic [47:0]          mapped_count,
  output logic                 status
);

  rlim_pkg::op_t    op_r;
  rlim_pkg::index_t value_r;
  rlim_pkg::index_t index_r;

  rlim_pkg::count_t run_count;
  rlim_pkg::index_t last_src_start;
  rlim_pkg::index_t last_src_end;
  rlim_pkg::index_t last_dst_start;
  rlim_pkg::index_t last_dst_end;

  rlim_pkg::count_t lo;
  rlim_pkg::count_t hi;
  rlim_pkg::count_t mid;

  logic             hit;
  rlim_pkg::index_t offset;
  rlim_pkg::index_t dst_base;
  logic             res_found;
  rlim_pkg::index_t res_dest;
  logic             res_status;

  rlim_pkg::run_entry_t wr_entry;
  rlim_pkg::run_entry_t rd_entry;
  logic                 ram_we;
  rlim_pkg::count_t     wr_slot;
  rlim_pkg::count_t     rd_slot;

  rlim_pkg::index_t next_src;
  logic             src_full;
  logic             can_extend;
  logic             table_full;

  logic             go_right;
  rlim_pkg::count_t lo_step;
  rlim_pkg::count_t hi_step;
  rlim_pkg::count_t mid_step;
  logic             search_more;
  rlim_pkg::index_t count_now;

  // append decision
  always_comb begin
    next_src   = last_src_end + rlim_pkg::INDEX_BITS'(1);
    src_full   = (last_src_end == rlim_pkg::IDX_ONES);
    can_extend = (last_dst_end != rlim_pkg::IDX_ONES) &&
                 (last_dst_end + rlim_pkg::INDEX_BITS'(1) == value_r);
    table_full = (run_count == rlim_pkg::COUNT_MAX);
  end

  always_comb begin
    ram_we   = 1'b0;
    wr_slot  = run_count;
    wr_entry = '{src_start: next_src, src_end: next_src, dst_start: value_r};
    if (cmd.append) begin
      if (run_count == '0) begin
        ram_we   = 1'b1;
        wr_slot  = '0;
        wr_entry = '{src_start: '0, src_end: '0, dst_start: value_r};
      end else if (!src_full) begin
        if (can_extend) begin
          ram_we   = 1'b1;
          wr_slot  = run_count - rlim_pkg::COUNT_W'(1);
          wr_entry = '{src_start: last_src_start, src_end: next_src,
                       dst_start: last_dst_start};
        end else if (!table_full) begin
          ram_we = 1'b1;
        end
      end
    end
  end

  // one search step per cycle on the entry read at mid
  always_comb begin
    go_right    = (rd_entry.src_end < index_r);
    lo_step     = go_right ? mid + rlim_pkg::COUNT_W'(1) : lo;
    hi_step     = go_right ? hi : mid;
    search_more = (lo_step < hi_step);
    mid_step    = lo_step + ((hi_step - lo_step) >> 1);
    if (cmd.search_init) begin
      rd_slot = run_count >> 1;
    end else if (search_more) begin
      rd_slot = mid_step;
    end else begin
      rd_slot = lo_step;
    end
  end

  rlim_ram #(
    .WIDTH ($bits(rlim_pkg::run_entry_t)),
    .DEPTH (rlim_pkg::MAX_RUNS)
  ) u_runs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot[rlim_pkg::RUN_AW-1:0]),
    .wdata (wr_entry),
    .raddr (rd_slot[rlim_pkg::RUN_AW-1:0]),
    .rdata (rd_entry)
  );

  // table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
    end else if (cmd.clear) begin
      run_count <= '0;
    end else if (cmd.append && ram_we && !(run_count != '0 && can_extend)) begin
      run_count <= run_count + rlim_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && ram_we) begin
      last_src_start <= wr_entry.src_start;
      last_src_end   <= wr_entry.src_end;
      last_dst_start <= wr_entry.dst_start;
      last_dst_end   <= value_r;
    end
  end

  // item capture, search and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= rlim_pkg::op_t'(op);
      value_r    <= append_value;
      index_r    <= lookup_index;
      hit        <= 1'b0;
      res_found  <= 1'b0;
      res_dest   <= '0;
      res_status <= 1'b0;
    end
    if (cmd.append) begin
      res_status <= !ram_we;
    end
    if (cmd.search_init) begin
      lo  <= '0;
      hi  <= run_count;
      mid <= rd_slot;
    end
    if (cmd.search_step) begin
      lo  <= lo_step;
      hi  <= hi_step;
      mid <= rd_slot;
    end
    if (cmd.final_check) begin
      hit      <= (lo < run_count) && (index_r >= rd_entry.src_start);
      offset   <= index_r - rd_entry.src_start;
      dst_base <= rd_entry.dst_start;
    end
    if (cmd.add_dest) begin
      res_found <= hit;
      res_dest  <= hit ? offset + dst_base : '0;
    end
  end

  assign count_now = (run_count == '0) ? '0 : last_src_end + rlim_pkg::INDEX_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found        <= res_found;
      dest_index   <= res_dest;
      mapped_count <= count_now;
      status       <= res_status;
    end
  end

  always_comb begin
    stat.op          = op_r;
    stat.empty       = (run_count == '0);
    stat.search_more = search_more;
    stat.out_free    = !out_valid || out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    run_count <= rlim_pkg::COUNT_MAX)
    else $error("run count beyond table size");

  a_search_open: assert property (@(posedge clk) disable iff (rst)
    cmd.search_step |-> lo < hi)
    else $error("search step on empty interval");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> dest_index == '0)
    else $error("miss with nonzero destination");

  a_hit_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> !status)
    else $error("hit reported together with dropped append");

endmodule

`default_nettype wire

>>> design/run_length_index_map_top.sv
// ----------------------------------------------------------------------------
// run_length_index_map_top
// Maps dense source indexes to destination indexes kept as a run table.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_ready    op, append_value, lookup_index
//   out       source     out_valid/out_ready  found, dest_index, mapped_count,
//                                             status
//
// One word in, one word out. Append, clear, no-op and a lookup on an empty
// table pass from the execute state straight to the result state. Any other
// lookup steps through search, final check and add states first: the binary
// search issues one read of the run RAM per cycle and compares the registered
// data in the next one.
// Reset is synchronous and empties the table; RAM contents need no clearing.
// A new word is taken while the previous result still waits at the output;
// the block then holds in its result state until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_index_map_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [47:0] append_value,
  input  wire logic [47:0] lookup_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic [47:0]      dest_index,
  output logic [47:0]      mapped_count,
  output logic             status
);

  // command and status between sequencer and datapath
  rlim_pkg::cmd_t  cmd;
  rlim_pkg::stat_t stat;

  // sequencer: advance through append, clear or search steps
  rlim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: run table, search registers and output word
  rlim_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .append_value (append_value),
    .lookup_index (lookup_index),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .found        (found),
    .dest_index   (dest_index),
    .mapped_count (mapped_count),
    .status       (status)
  );

endmodule

`default_nettype wire
